[hdl/mmp_pkg.sv]
// ----------------------------------------------------------------------------
// mmp_pkg: shared types and helpers for the MIDI message parser
// Word layouts of both channels, the parse phase type and the table that
// gives the number of data bytes that follow a status byte.
// ----------------------------------------------------------------------------
`default_nettype none

package mmp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned DATA_W = 7;

	// Real-time bytes start here and pass through at once.
	localparam logic [BYTE_W-1:0] REALTIME_FIRST = 8'hF8;
	// Status bytes from here on are system messages and never run.
	localparam logic [BYTE_W-1:0] SYSTEM_FIRST   = 8'hF0;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              rx_error;
	} rx_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0] msg_status;
		logic [DATA_W-1:0] msg_data1;
		logic [DATA_W-1:0] msg_data2;
	} msg_word_t;

	typedef enum logic [1:0] {
		PH_WAIT   = 2'd0,
		PH_ONLY   = 2'd1,
		PH_FIRST  = 2'd2,
		PH_SECOND = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		LEN_NONE = 2'd0,
		LEN_ZERO = 2'd1,
		LEN_ONE  = 2'd2,
		LEN_TWO  = 2'd3
	} data_len_t;

	// Number of data bytes that a status byte takes; LEN_NONE when the
	// byte is data or a status that is not assembled.
	function automatic data_len_t data_len(input logic [BYTE_W-1:0] s);
		data_len_t len;
		len = LEN_NONE;
		unique case (s[7:4])
			4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = LEN_TWO;
			4'hC, 4'hD:                   len = LEN_ONE;
			4'hF: begin
				unique case (s[3:0])
					4'h1, 4'h3: len = LEN_ONE;
					4'h2:       len = LEN_TWO;
					4'h6:       len = LEN_ZERO;
					default:    len = LEN_NONE;
				endcase
			end
			default: len = LEN_NONE;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

[hdl/mmp_parser.sv]
// ----------------------------------------------------------------------------
// mmp_parser: running status message assembler
// Holds the parse state and turns one received word into at most one
// completed message in the cycle it is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module mmp_parser
	import mmp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      consume,
	input  wire rx_word_t  word,
	output logic           res_valid,
	output msg_word_t      res
);

	phase_t            phase_q, phase_n;
	logic [BYTE_W-1:0] held_status_q, held_status_n;
	logic [DATA_W-1:0] held_first_q, held_first_n;
	logic [BYTE_W-1:0] running_q, running_n;
	data_len_t         len_byte, len_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_WAIT;
			held_status_q <= '0;
			held_first_q  <= '0;
			running_q     <= '0;
		end else if (consume) begin
			phase_q       <= phase_n;
			held_status_q <= held_status_n;
			held_first_q  <= held_first_n;
			running_q     <= running_n;
		end
	end

	assign len_byte = data_len(word.rx_byte);
	assign len_run  = data_len(running_q);

	always_comb begin
		phase_n       = phase_q;
		held_status_n = held_status_q;
		held_first_n  = held_first_q;
		running_n     = running_q;
		res_valid     = 1'b0;
		res           = '{msg_status: word.rx_byte, msg_data1: '0, msg_data2: '0};

		if (word.rx_error) begin
			phase_n   = PH_WAIT;
			running_n = '0;
		end else if (word.rx_byte >= REALTIME_FIRST) begin
			// Real-time bytes go out at once and leave the parse alone.
			res_valid = 1'b1;
		end else if (word.rx_byte[7]) begin
			running_n = (word.rx_byte < SYSTEM_FIRST) ? word.rx_byte : '0;
			unique case (len_byte)
				LEN_NONE: phase_n = PH_WAIT;
				LEN_ZERO: begin
					held_status_n = word.rx_byte;
					phase_n       = PH_WAIT;
					res_valid     = 1'b1;
				end
				LEN_ONE: begin
					held_status_n = word.rx_byte;
					phase_n       = PH_ONLY;
				end
				LEN_TWO: begin
					held_status_n = word.rx_byte;
					phase_n       = PH_FIRST;
				end
				default: phase_n = PH_WAIT;
			endcase
		end else begin
			unique case (phase_q)
				PH_ONLY: begin
					phase_n   = PH_WAIT;
					res_valid = 1'b1;
					res       = '{msg_status: held_status_q,
					              msg_data1: word.rx_byte[DATA_W-1:0], msg_data2: '0};
				end
				PH_FIRST: begin
					held_first_n = word.rx_byte[DATA_W-1:0];
					phase_n      = PH_SECOND;
				end
				PH_SECOND: begin
					phase_n   = PH_WAIT;
					res_valid = 1'b1;
					res       = '{msg_status: held_status_q, msg_data1: held_first_q,
					              msg_data2: word.rx_byte[DATA_W-1:0]};
				end
				default: begin
					// Waiting: a data byte reuses the running status if any.
					if (running_q != '0) begin
						held_status_n = running_q;
						if (len_run == LEN_ONE) begin
							res_valid = 1'b1;
							res       = '{msg_status: running_q,
							              msg_data1: word.rx_byte[DATA_W-1:0],
							              msg_data2: '0};
						end else if (len_run == LEN_TWO) begin
							held_first_n = word.rx_byte[DATA_W-1:0];
							phase_n      = PH_SECOND;
						end else begin
							running_n = '0;
						end
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/mmp_out_buf.sv]
// ----------------------------------------------------------------------------
// mmp_out_buf: two-entry result buffer
// Output register plus one skid entry, so the parser can still push one
// more message after the receiver starts to stall.
// ----------------------------------------------------------------------------
`default_nettype none

module mmp_out_buf
	import mmp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire msg_word_t push_word,
	output logic           full,
	output logic           msg_valid,
	input  wire logic      msg_stall,
	output msg_word_t      msg_word
);

	logic [1:0] count_q;
	msg_word_t  head_q, skid_q;
	logic       pop;

	assign pop       = msg_valid && !msg_stall;
	assign msg_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign msg_word  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (count_q == 2'd2) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= push_word;
				end
			end else if (push) begin
				head_q <= push_word;
			end
		end else if (push) begin
			if (count_q == 2'd0) begin
				head_q <= push_word;
			end else begin
				skid_q <= push_word;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/midi_message_parser_top.sv]
// ----------------------------------------------------------------------------
// midi_message_parser_top: MIDI message parser with running status
// Assembles MIDI messages from received UART bytes, one byte per cycle while rx_stall is low.
// ----------------------------------------------------------------------------
// Usage:
// The rx channel carries one received byte and its line-error flag per word.
// A word is taken at a rising edge where rx_valid is high and rx_stall low.
// The msg channel delivers one completed message per word (status, first
// and second data byte, unused data bytes are zero) under the same rule.
// Throughput is one rx word per cycle while rx_stall is low. A word first
// lands in an input register; the parser consumes it from there once the
// result buffer has room, updates its state and, if a message completes,
// writes it into the output buffer at the same edge. A message thus passes
// the input register and the output buffer before it is presented on msg.
// Real-time bytes come out at once, even inside a message, and an errored
// byte drops the partial message and clears running status.
// The output side is a two-entry buffer. When the receiver stalls, the
// parser keeps consuming until both entries are full, then holds the word
// in the input register and raises rx_stall; rx_stall comes from registers.
// Reset clears the parse state and running status and empties both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_message_parser_top
	import mmp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      rx_valid,
	output logic           rx_stall,
	input  wire rx_word_t  rx_word,
	output logic           msg_valid,
	input  wire logic      msg_stall,
	output msg_word_t      msg_word
);

	logic      valid_s1;
	rx_word_t  word_s1;
	logic      consume;
	logic      full;
	logic      res_valid;
	msg_word_t res;

	// The held word is consumed whenever the result buffer has room; the
	// input register is then free for the next word in the same cycle.
	assign consume  = valid_s1 && !full;
	assign rx_stall = valid_s1 && full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			word_s1 <= rx_word;
		end
	end

	mmp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.consume   (consume),
		.word      (word_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	mmp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (consume && res_valid),
		.push_word (res),
		.full      (full),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg_word  (msg_word)
	);

endmodule

`default_nettype wire

[tb/midi_codes_pkg.sv]
// ----------------------------------------------------------------------------
// midi_codes_pkg: MIDI status codes for the parser testbench
// Named status bytes shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package midi_codes_pkg;

	// Channel messages; the low nibble is the channel.
	localparam logic [7:0] ST_NOTE_OFF      = 8'h80;
	localparam logic [7:0] ST_NOTE_ON       = 8'h90;
	localparam logic [7:0] ST_CTRL          = 8'hB0;
	localparam logic [7:0] ST_PROGRAM       = 8'hC0;
	localparam logic [7:0] ST_PRESSURE      = 8'hD0;
	localparam logic [7:0] ST_BEND          = 8'hE0;
	localparam logic [7:0] CHAN_MASK        = 8'h0F;

	// System common messages and the undefined codes among them.
	localparam logic [7:0] ST_SYSEX         = 8'hF0;
	localparam logic [7:0] ST_QUARTER_FRAME = 8'hF1;
	localparam logic [7:0] ST_SONG_POS      = 8'hF2;
	localparam logic [7:0] ST_SONG_SELECT   = 8'hF3;
	localparam logic [7:0] ST_UNDEF_F4      = 8'hF4;
	localparam logic [7:0] ST_UNDEF_F5      = 8'hF5;
	localparam logic [7:0] ST_TUNE_REQUEST  = 8'hF6;
	localparam logic [7:0] ST_EOX           = 8'hF7;

	// Real-time range, first and last.
	localparam logic [7:0] ST_CLOCK         = 8'hF8;
	localparam logic [7:0] ST_SYS_RESET     = 8'hFF;

endpackage

[tb/midi_message_parser_checker.sv]
// ----------------------------------------------------------------------------
// midi_message_parser_checker: message scoreboard for the MIDI parser
// Follows every byte taken on the rx channel with its own parse state,
// queues the message it should produce, and compares each message taken
// on the msg channel with the oldest queued one, field by field.
// ----------------------------------------------------------------------------
module midi_message_parser_checker
	import mmp_pkg::*;
	import midi_codes_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic rx_valid,
	input  wire logic rx_stall,
	input  rx_word_t  rx_word,
	input  wire logic msg_valid,
	input  wire logic msg_stall,
	input  msg_word_t msg_word,
	output int        fail_count,
	output int        pending,
	output int        msgs_checked
);

	phase_t          phase;
	logic [7:0]      cur_status;
	logic [6:0]      first_data;
	logic [7:0]      run_status;
	msg_word_t       expected_msgs[$];

	function automatic data_len_t byte_count(input logic [7:0] s);
		if (s < ST_NOTE_OFF)
			return LEN_NONE;
		if (s < ST_PROGRAM || (s >= ST_BEND && s < ST_SYSEX))
			return LEN_TWO;
		if (s < ST_BEND)
			return LEN_ONE;
		case (s)
			ST_QUARTER_FRAME, ST_SONG_SELECT: return LEN_ONE;
			ST_SONG_POS:                      return LEN_TWO;
			ST_TUNE_REQUEST:                  return LEN_ZERO;
			default:                          return LEN_NONE;
		endcase
	endfunction

	// Advances the parse by one byte; returns 1 when a message completes.
	function automatic bit predict_message(input rx_word_t w, output msg_word_t m);
		data_len_t n;
		m = '0;
		if (w.rx_error) begin
			phase = PH_WAIT;
			run_status = '0;
			return 1'b0;
		end
		if (w.rx_byte >= REALTIME_FIRST) begin
			m.msg_status = w.rx_byte;
			return 1'b1;
		end
		if (w.rx_byte[7]) begin
			n = byte_count(w.rx_byte);
			run_status = (w.rx_byte < SYSTEM_FIRST) ? w.rx_byte : 8'h00;
			if (n == LEN_NONE) begin
				phase = PH_WAIT;
				return 1'b0;
			end
			cur_status = w.rx_byte;
			if (n == LEN_ZERO) begin
				phase = PH_WAIT;
				m.msg_status = w.rx_byte;
				return 1'b1;
			end
			phase = (n == LEN_ONE) ? PH_ONLY : PH_FIRST;
			return 1'b0;
		end
		case (phase)
			PH_ONLY: begin
				phase = PH_WAIT;
				m.msg_status = cur_status;
				m.msg_data1 = w.rx_byte[6:0];
				return 1'b1;
			end
			PH_FIRST: begin
				first_data = w.rx_byte[6:0];
				phase = PH_SECOND;
				return 1'b0;
			end
			PH_SECOND: begin
				phase = PH_WAIT;
				m.msg_status = cur_status;
				m.msg_data1 = first_data;
				m.msg_data2 = w.rx_byte[6:0];
				return 1'b1;
			end
			default: begin
				// Waiting: a data byte only starts a message under running status.
				if (run_status == 8'h00)
					return 1'b0;
				n = byte_count(run_status);
				cur_status = run_status;
				if (n == LEN_ONE) begin
					m.msg_status = run_status;
					m.msg_data1 = w.rx_byte[6:0];
					return 1'b1;
				end
				if (n == LEN_TWO) begin
					first_data = w.rx_byte[6:0];
					phase = PH_SECOND;
					return 1'b0;
				end
				run_status = 8'h00;
				return 1'b0;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		fail_count++;
		$display("mismatch at message %0d: %s is %02h, expected %02h",
			msgs_checked, what, got, want);
	endtask

	// Messages are compared before the byte of the same edge is predicted,
	// since that byte cannot have produced a message yet.
	always @(posedge clk or negedge arst_n) begin
		msg_word_t want;
		msg_word_t next_msg;
		if (!arst_n) begin
			phase = PH_WAIT;
			cur_status = '0;
			first_data = '0;
			run_status = '0;
			expected_msgs.delete();
		end else begin
			if (msg_valid && !msg_stall) begin
				if (expected_msgs.size() == 0) begin
					report_mismatch("unexpected message, status",
						int'(msg_word.msg_status), 0);
				end else begin
					want = expected_msgs.pop_front();
					if (msg_word.msg_status !== want.msg_status)
						report_mismatch("msg_status", int'(msg_word.msg_status),
							int'(want.msg_status));
					if (msg_word.msg_data1 !== want.msg_data1)
						report_mismatch("msg_data1", int'(msg_word.msg_data1),
							int'(want.msg_data1));
					if (msg_word.msg_data2 !== want.msg_data2)
						report_mismatch("msg_data2", int'(msg_word.msg_data2),
							int'(want.msg_data2));
				end
				msgs_checked++;
			end
			if (rx_valid && !rx_stall) begin
				if (predict_message(rx_word, next_msg))
					expected_msgs.push_back(next_msg);
			end
		end
		pending = expected_msgs.size();
	end

endmodule

[tb/midi_message_parser_top_tb.sv]
// ----------------------------------------------------------------------------
// midi_message_parser_top_tb: testbench top for the MIDI message parser
// Sends a directed byte sequence and then random MIDI traffic through the
// parser under four pacing phases; the checker beside the block predicts
// every message and compares. The top drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module midi_message_parser_top_tb;
	import mmp_pkg::*;
	import midi_codes_pkg::*;

	// Cycles without any word moving on either channel before giving up.
	// The longest legal quiet stretch is a random stall run or the short
	// tail after the last byte, both far below this.
	localparam int WATCHDOG_LIMIT = 4000;
	// Bytes per random phase; with the directed part this gives about 950.
	localparam int PHASE_ITEMS = 230;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      rx_valid = 1'b0;
	logic      rx_stall;
	rx_word_t  rx_word = '0;
	logic      msg_valid;
	logic      msg_stall = 1'b0;
	msg_word_t msg_word;

	int        fail_count;
	int        pending;
	int        msgs_checked;

	// Pacing knobs, in percent of cycles.
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned idle_by_phase[4] = '{0, 81, 0, 18};
	int unsigned stall_by_phase[4] = '{0, 0, 81, 18};

	int        items_sent = 0;
	int        quiet_cycles = 0;
	// Channel status the random traffic keeps reusing, so that running
	// status gets real exercise; zero when the next message needs a status.
	logic [7:0] chan_status = 8'h00;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	midi_message_parser_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_word   (rx_word),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg_word  (msg_word)
	);

	midi_message_parser_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_word      (rx_word),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.msg_word     (msg_word),
		.fail_count   (fail_count),
		.pending      (pending),
		.msgs_checked (msgs_checked)
	);

	// The receiver stalls at random, decided fresh every cycle at the
	// falling edge so that the block sees a settled value at the rising one.
	always @(negedge clk) begin
		msg_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watchdog: any accepted word on either side restarts the count.
	always @(posedge clk) begin
		if ((rx_valid && !rx_stall) || (msg_valid && !msg_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no word moved for %0d cycles, %0d messages outstanding",
				WATCHDOG_LIMIT, pending);
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Presents one word at a falling edge and holds it until the rising edge
	// that takes it; returns at the following falling edge. Idle cycles are
	// inserted in front according to the current sender pacing. Bytes sent with
	// counted clear are not counted toward the item budget.
	task automatic send_word(input logic [7:0] b, input logic err, input bit counted);
		rx_word_t w;
		while ($urandom_range(99) < send_idle_pct) begin
			rx_valid <= 1'b0;
			@(negedge clk);
		end
		w.rx_byte = b;
		w.rx_error = err;
		rx_valid <= 1'b1;
		rx_word <= w;
		@(posedge clk);
		while (rx_stall)
			@(posedge clk);
		@(negedge clk);
		if (counted)
			items_sent++;
	endtask

	// A data byte, now and then preceded by a real-time byte, which the
	// parser must emit without disturbing the message in progress.
	task automatic send_data();
		if ($urandom_range(99) < 4)
			send_word(8'(ST_CLOCK + $urandom_range(7)), 1'b0, 1'b1);
		send_word(8'($urandom_range(127)), 1'b0, 1'b1);
	endtask

	// Stops sending and waits until every predicted message has come out.
	task automatic drain_messages();
		rx_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic send_directed();
		// Note on with data extremes, then the same status running.
		send_word(ST_NOTE_ON, 1'b0, 1'b1);
		send_word(8'h7F, 1'b0, 1'b1);
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'h7F, 1'b0, 1'b1);
		// Highest one-byte channel status.
		send_word(ST_PRESSURE | CHAN_MASK, 1'b0, 1'b1);
		send_word(8'h7F, 1'b0, 1'b1);
		// A real-time byte in the middle of a control change.
		send_word(ST_CTRL, 1'b0, 1'b1);
		send_word(8'h07, 1'b0, 1'b1);
		send_word(ST_SYS_RESET, 1'b0, 1'b1);
		send_word(8'h40, 1'b0, 1'b1);
		// System common messages of each length; a data byte after the
		// quarter frame finds no running status and is dropped.
		send_word(ST_SONG_POS, 1'b0, 1'b1);
		send_word(8'h01, 1'b0, 1'b1);
		send_word(8'h02, 1'b0, 1'b1);
		send_word(ST_QUARTER_FRAME, 1'b0, 1'b1);
		send_word(8'h11, 1'b0, 1'b1);
		send_word(8'h22, 1'b0, 1'b1);
		send_word(ST_TUNE_REQUEST, 1'b0, 1'b1);
		// System exclusive is not assembled; its data is ignored.
		send_word(ST_SYSEX, 1'b0, 1'b1);
		send_word(8'h12, 1'b0, 1'b1);
		send_word(ST_EOX, 1'b0, 1'b1);
		// A line error, even on a real-time byte, drops the partial
		// message and running status, so the next data byte goes nowhere.
		send_word(ST_BEND | CHAN_MASK, 1'b0, 1'b1);
		send_word(8'h10, 1'b0, 1'b1);
		send_word(ST_SYS_RESET, 1'b1, 1'b1);
		send_word(8'h7F, 1'b0, 1'b1);
		// A new status cuts a message short.
		send_word(ST_NOTE_OFF, 1'b0, 1'b1);
		send_word(8'h10, 1'b0, 1'b1);
		send_word(ST_PROGRAM, 1'b0, 1'b1);
		send_word(8'h05, 1'b0, 1'b1);
		send_word(8'h00, 1'b1, 1'b1);
	endtask

	// Mostly complete messages with random content, some relying on running
	// status, mixed with real-time bytes, errors, undefined codes, stray
	// data and truncated messages.
	task automatic send_random_message();
		int unsigned pick;
		int unsigned n;
		logic [7:0]  s;
		pick = $urandom_range(99);
		if (pick < 68) begin
			if (chan_status == 8'h00 || $urandom_range(2) == 0) begin
				chan_status = 8'(ST_NOTE_OFF + $urandom_range(111));
				send_word(chan_status, 1'b0, 1'b1);
			end
			n = (chan_status[7:5] == ST_PROGRAM[7:5]) ? 1 : 2;
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(99) < 2) begin
					send_word(8'($urandom_range(255)), 1'b1, 1'b1);
					chan_status = 8'h00;
				end else begin
					send_data();
				end
			end
		end else if (pick < 80) begin
			case ($urandom_range(3))
				0: begin s = ST_QUARTER_FRAME; n = 1; end
				1: begin s = ST_SONG_POS;      n = 2; end
				2: begin s = ST_SONG_SELECT;   n = 1; end
				default: begin s = ST_TUNE_REQUEST; n = 0; end
			endcase
			chan_status = 8'h00;
			send_word(s, 1'b0, 1'b1);
			for (int i = 0; i < n; i++)
				send_data();
		end else if (pick < 87) begin
			send_word(8'(ST_CLOCK + $urandom_range(7)), 1'b0, 1'b1);
		end else if (pick < 92) begin
			case ($urandom_range(3))
				0: s = ST_SYSEX;
				1: s = ST_UNDEF_F4;
				2: s = ST_UNDEF_F5;
				default: s = ST_EOX;
			endcase
			chan_status = 8'h00;
			send_word(s, 1'b0, 1'b1);
			n = $urandom_range(3);
			for (int i = 0; i < n; i++)
				send_word(8'($urandom_range(127)), 1'b0, 1'b0);
		end else if (pick < 96) begin
			send_word(8'($urandom_range(255)), 1'b1, 1'b1);
			chan_status = 8'h00;
		end else if (pick < 98) begin
			send_word(8'($urandom_range(127)), 1'b0, 1'b0);
		end else begin
			// Only the status and one data byte; for a two-byte status whatever follows interrupts.
			chan_status = 8'(ST_NOTE_OFF + $urandom_range(111));
			send_word(chan_status, 1'b0, 1'b1);
			send_data();
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_directed();
		drain_messages();

		// Each phase ends with the sender paused until all messages are out.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_by_phase[p];
			stall_pct = stall_by_phase[p];
			while (items_sent < 30 + PHASE_ITEMS * (p + 1))
				send_random_message();
			drain_messages();
		end

		stall_pct = 0;
		repeat (20) @(negedge clk);

		$display("Run covered %0d bytes: a directed sequence, then random MIDI traffic",
			items_sent);
		$display("under free flow, idle sender, stalling receiver and both; %0d messages.",
			msgs_checked);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
